// ===== rtl/ntr_pkg.sv =====
// ----------------------------------------------------------------------------
// ntr_pkg: shared definitions for the NFA token recognizer
// Command codes carried on the input channel.
// ----------------------------------------------------------------------------
`default_nettype none

package ntr_pkg;

  typedef enum logic [1:0] {
    CMD_ADD_TRANS = 2'd0,
    CMD_SET_FINAL = 2'd1,
    CMD_START     = 2'd2,
    CMD_CONSUME   = 2'd3
  } cmd_t;

endpackage

`default_nettype wire

// ===== rtl/ntr_ram.sv =====
// ----------------------------------------------------------------------------
// ntr_ram: generic simple dual-port RAM
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
`default_nettype none

module ntr_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 4096
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

// ===== rtl/nfa_token_recognizer.sv =====
// ----------------------------------------------------------------------------
// nfa_token_recognizer: NFA simulation with epsilon closure
// Builds an automaton from commands and tracks the active state set over a
// symbol stream, reporting acceptance and the best token.
// ----------------------------------------------------------------------------
//  Channel  Signals                              Direction  Role
//  in       in_valid/in_ready, command..token_id in         commands and symbols
//  out      out_valid/out_ready, active_states.. out        report after start/consume
//  cfg      cfg_valid/cfg_ready, initial_state_index in     initial state register
//
// Add transition reads the transition RAM entry, then writes it back; set final
// is taken directly in idle. Consume runs move, closure and report, start runs
// closure and report: the M active states and C closure states are read one per
// cycle from the transition RAM, the F active final states have their tokens read
// from the token RAM. Each of these scans ends once its last read has returned,
// and the closure waits on a pending read whenever it has nothing else to visit.
// After reset a clearing pass writes every transition RAM entry, one per
// cycle, 2**($clog2(NUM_STATES)+SYMBOL_BITS) entries (4096 by default); input
// is held off meanwhile, configuration writes are always taken.
// A report that is not yet taken holds the next report back in its last step.
// ----------------------------------------------------------------------------
`default_nettype none

module nfa_token_recognizer #(
  parameter int NUM_STATES  = 16,
  parameter int SYMBOL_BITS = 8,
  parameter int TOKEN_BITS  = 8
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        in_valid,
  output logic             in_ready,
  input  wire logic [1:0]  command,
  input  wire logic [3:0]  state_index,
  input  wire logic [7:0]  symbol,
  input  wire logic [3:0]  target_state,
  input  wire logic [7:0]  token_id,
  output logic             out_valid,
  input  wire logic        out_ready,
  output logic [15:0]      active_states,
  output logic             accepting,
  output logic [7:0]       best_token,
  output logic             finished,
  input  wire logic        cfg_valid,
  output logic             cfg_ready,
  input  wire logic [3:0]  initial_state_index
);

  localparam int SW       = $clog2(NUM_STATES);
  localparam int TM_AW    = SW + SYMBOL_BITS;
  localparam int TM_DEPTH = 1 << TM_AW;
  localparam int TOK_W    = (TOKEN_BITS < 8) ? TOKEN_BITS : 8;

  typedef enum logic [2:0] {
    ST_CLEAR, ST_IDLE, ST_TR_WRITE, ST_MOVE, ST_CLOSE, ST_REPORT
  } fsm_t;

  fsm_t                   state;
  logic [TM_AW-1:0]       clr_cnt;
  logic [3:0]             init_idx;
  logic [SW-1:0]          st_q;
  logic [SYMBOL_BITS-1:0] sym_q;
  logic [SW-1:0]          tgt_q;
  logic [NUM_STATES-1:0]  cur_set;
  logic [NUM_STATES-1:0]  work;
  logic [NUM_STATES-1:0]  done;
  logic [NUM_STATES-1:0]  final_flags;
  logic                   rd_busy;
  logic [TOK_W-1:0]       best;
  logic [NUM_STATES-1:0]  out_set;
  logic [TOK_W-1:0]       best_token_q;

  logic [NUM_STATES-1:0]  pend;
  logic                   pend_any;
  logic [SW-1:0]          pick;
  logic                   in_acc;
  logic                   st_ok;
  logic                   tgt_ok;
  logic                   init_ok;
  logic                   tok_better;
  logic                   rep_end;

  logic                   tm_we;
  logic [TM_AW-1:0]       tm_waddr;
  logic [NUM_STATES-1:0]  tm_wdata;
  logic [TM_AW-1:0]       tm_raddr;
  logic [NUM_STATES-1:0]  tm_rdata;
  logic                   tk_we;
  logic [TOK_W-1:0]       tk_rdata;

  assign in_ready  = (state == ST_IDLE);
  assign cfg_ready = 1'b1;
  assign in_acc    = in_valid && in_ready;
  assign st_ok     = (32'(state_index) < NUM_STATES);
  assign tgt_ok    = (32'(target_state) < NUM_STATES);
  assign init_ok   = (32'(init_idx) < NUM_STATES);

  assign active_states = 16'(out_set);
  assign best_token    = 8'(best_token_q);

  // States still to visit in the current scan.
  always_comb begin
    case (state)
      ST_MOVE:   pend = cur_set & ~done;
      ST_CLOSE:  pend = work & ~done;
      ST_REPORT: pend = cur_set & final_flags & ~done;
      default:   pend = '0;
    endcase
    pend_any = |pend;
    pick     = '0;
    for (int i = NUM_STATES - 1; i >= 0; i--) begin
      if (pend[i]) begin
        pick = SW'(i);
      end
    end
  end

  assign tok_better = rd_busy && (tk_rdata != '0) && ((best == '0) || (tk_rdata < best));
  assign rep_end    = !pend_any && !rd_busy && (!out_valid || out_ready);

  always_comb begin
    tm_we    = 1'b0;
    tm_waddr = {st_q, sym_q};
    tm_wdata = tm_rdata | (NUM_STATES'(1) << tgt_q);
    tm_raddr = {SW'(state_index), symbol[SYMBOL_BITS-1:0]};
    unique case (state)
      ST_CLEAR: begin
        tm_we    = 1'b1;
        tm_waddr = clr_cnt;
        tm_wdata = '0;
      end
      ST_TR_WRITE: tm_we = 1'b1;
      ST_MOVE:     tm_raddr = {pick, sym_q};
      ST_CLOSE:    tm_raddr = {pick, {SYMBOL_BITS{1'b0}}};
      default:     ;
    endcase
  end

  assign tk_we = in_acc && (ntr_pkg::cmd_t'(command) == ntr_pkg::CMD_SET_FINAL) && st_ok;

  ntr_ram #(
    .WIDTH (NUM_STATES),
    .DEPTH (TM_DEPTH)
  ) u_trans_ram (
    .clk   (clk),
    .we    (tm_we),
    .waddr (tm_waddr),
    .wdata (tm_wdata),
    .raddr (tm_raddr),
    .rdata (tm_rdata)
  );

  // Tokens need no clearing: one is read only where its final flag is set.
  ntr_ram #(
    .WIDTH (TOK_W),
    .DEPTH (1 << SW)
  ) u_token_ram (
    .clk   (clk),
    .we    (tk_we),
    .waddr (SW'(state_index)),
    .wdata (token_id[TOK_W-1:0]),
    .raddr (pick),
    .rdata (tk_rdata)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= ST_CLEAR;
      clr_cnt     <= '0;
      init_idx    <= '0;
      final_flags <= '0;
      cur_set     <= '0;
      rd_busy     <= 1'b0;
      out_valid   <= 1'b0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        init_idx <= initial_state_index;
      end
      if ((state == ST_REPORT) && rep_end) begin
        out_valid <= 1'b1;
      end else if (out_valid && out_ready) begin
        out_valid <= 1'b0;
      end

      unique case (state)
        ST_CLEAR: begin
          clr_cnt <= clr_cnt + 1'b1;
          if (&clr_cnt) begin
            state <= ST_IDLE;
          end
        end

        ST_IDLE: begin
          if (in_acc) begin
            st_q    <= SW'(state_index);
            sym_q   <= symbol[SYMBOL_BITS-1:0];
            tgt_q   <= SW'(target_state);
            done    <= '0;
            rd_busy <= 1'b0;
            unique case (ntr_pkg::cmd_t'(command))
              ntr_pkg::CMD_ADD_TRANS: begin
                if (st_ok && tgt_ok) begin
                  state <= ST_TR_WRITE;
                end
              end
              ntr_pkg::CMD_SET_FINAL: begin
                if (st_ok) begin
                  final_flags[SW'(state_index)] <= 1'b1;
                end
              end
              ntr_pkg::CMD_START: begin
                work  <= init_ok ? (NUM_STATES'(1) << SW'(init_idx)) : '0;
                state <= ST_CLOSE;
              end
              ntr_pkg::CMD_CONSUME: begin
                work  <= '0;
                state <= ST_MOVE;
              end
              default: ;
            endcase
          end
        end

        ST_TR_WRITE: state <= ST_IDLE;

        // Move and closure issue one RAM read per cycle; its data arrives in the following cycle.
        ST_MOVE, ST_CLOSE: begin
          if (rd_busy) begin
            work <= work | tm_rdata;
          end
          if (pend_any) begin
            done[pick] <= 1'b1;
          end
          rd_busy <= pend_any;
          if (!pend_any && !rd_busy) begin
            done <= '0;
            if (state == ST_MOVE) begin
              state <= ST_CLOSE;
            end else begin
              cur_set <= work;
              best    <= '0;
              state   <= ST_REPORT;
            end
          end
        end

        ST_REPORT: begin
          if (tok_better) begin
            best <= tk_rdata;
          end
          if (pend_any) begin
            done[pick] <= 1'b1;
            rd_busy    <= 1'b1;
          end else if (!rd_busy) begin
            rd_busy <= 1'b0;
          end else begin
            rd_busy <= 1'b0;
          end
          if (rep_end) begin
            out_set      <= cur_set;
            accepting    <= |(cur_set & final_flags);
            finished     <= (cur_set == '0);
            best_token_q <= best;
            state        <= ST_IDLE;
          end
        end

        default: state <= ST_IDLE;
      endcase
    end
  end

  // A report is finished exactly when its set is empty.
  a_finished_empty: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (finished == (out_set == '0)))
    else $error("finished flag disagrees with the reported set");

  a_accept_nonempty: assert property (@(posedge clk) disable iff (rst)
    (out_valid && accepting) |-> !finished)
    else $error("accepting report with an empty set");

  a_token_needs_final: assert property (@(posedge clk) disable iff (rst)
    (out_valid && (best_token != 8'd0)) |-> accepting)
    else $error("token reported without an active final state");

  a_closure_visited: assert property (@(posedge clk) disable iff (rst)
    (state == ST_CLOSE) |-> ((done & ~work) == '0))
    else $error("closure visited a state outside the working set");

  a_report_source: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> $past(state == ST_REPORT))
    else $error("report raised outside the report step");

endmodule

`default_nettype wire
